// ===== src/binary_insertion_sorter_defines.svh =====
// Assertion macros shared by the binary insertion sorter RTL.
`ifndef BINARY_INSERTION_SORTER_DEFINES_SVH
`define BINARY_INSERTION_SORTER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BIS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define BIS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/bis_pkg.sv =====
// Types, sizes and state codes of the binary insertion sorter.
package bis_pkg;

    localparam int DATA_W = 32;
    localparam int DEPTH  = 16;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHIFT,
        S_SHWR,
        S_EMIT
    } t_state;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic start;
        logic in_last;
        logic full;
        logic last;
        logic lo_lt_hi;
        logic j_gt_pos;
        logic emit_end;
    } t_stat;

    // sequencer commands to the datapath
    typedef struct packed {
        logic busy;
        logic load;
        logic srch;
        logic cmp;
        logic shift_rd;
        logic shift_wr;
        logic insert;
        logic emit;
    } t_ctrl;

endpackage

// ===== src/binary_insertion_sorter.sv =====
// Sequence: binary search alternates a probe read (search) and a compare, then closes; each shifted
// entry is a read and a write, then the insert writes the item. After a non-last item busy is low
// again the cycle after the insert; a last item instead goes on to emit the set, each result strobed
// in the cycle after its read. One item at a time: a new item is taken only while busy is low.
// A dropped item (store full) that is not last leaves busy low. Results cannot be stalled. Reset (sync,
// active low) clears the count and flags; the store keeps stale contents, no clearing pass.
`include "binary_insertion_sorter_defines.svh"

module binary_insertion_sorter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bis_pkg::t_in_item i_item,
    output logic              busy,
    output logic              strobe,
    output bis_pkg::t_out_item o_result
);

    bis_pkg::t_stat stat;
    bis_pkg::t_ctrl ctrl;

    logic signed [bis_pkg::DATA_W-1:0] r_val, n_val;
    logic                              r_last, n_last;
    logic                              r_ovf, n_ovf;
    logic [bis_pkg::CW-1:0]            r_fill, n_fill;
    logic [bis_pkg::CW-1:0]            r_lo, n_lo;
    logic [bis_pkg::CW-1:0]            r_hi, n_hi;
    logic [bis_pkg::CW-1:0]            r_j, n_j;
    logic [bis_pkg::AW-1:0]            r_idx, n_idx;
    logic                              r_ov_v, n_ov_v;
    logic                              r_ov_last, n_ov_last;
    logic                              r_ov_ovf, n_ov_ovf;

    logic [bis_pkg::CW:0]              lo_hi_sum;
    logic [bis_pkg::CW-1:0]            mid;
    logic [bis_pkg::CW-1:0]            j_m1;
    logic                              ram_we;
    logic [bis_pkg::AW-1:0]            ram_waddr;
    logic [bis_pkg::DATA_W-1:0]        ram_wdata;
    logic [bis_pkg::AW-1:0]            ram_raddr;
    logic [bis_pkg::DATA_W-1:0]        ram_rdata;

    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[bis_pkg::CW:1];
    assign j_m1      = r_j - 1'b1;

    assign stat.start    = start;
    assign stat.in_last  = i_item.last_in;
    assign stat.full     = (r_fill == bis_pkg::CW'(bis_pkg::DEPTH));
    assign stat.last     = r_last;
    assign stat.lo_lt_hi = (r_lo < r_hi);
    assign stat.j_gt_pos = (r_j > r_lo);
    assign stat.emit_end = (bis_pkg::CW'(r_idx) == (r_fill - 1'b1));

    bis_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    bis_ram #(
        .WIDTH (bis_pkg::DATA_W),
        .DEPTH (bis_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_val     = r_val;
        n_last    = r_last;
        n_ovf     = r_ovf;
        n_fill    = r_fill;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_j       = r_j;
        n_idx     = r_idx;
        n_ov_v    = 1'b0;
        n_ov_last = r_ov_last;
        n_ov_ovf  = r_ov_ovf;
        ram_we    = 1'b0;
        ram_waddr = r_lo[bis_pkg::AW-1:0];
        ram_wdata = r_val;
        ram_raddr = mid[bis_pkg::AW-1:0];

        if (ctrl.load) begin
            n_val  = i_item.value;
            n_last = i_item.last_in;
            n_lo   = '0;
            n_hi   = r_fill;
            n_j    = r_fill;
            n_idx  = '0;
            if (stat.full) begin
                n_ovf = 1'b1;
            end
        end

        // probe result arrives in the cycle after the read issued in search
        if (ctrl.cmp) begin
            if ($signed(ram_rdata) <= r_val) begin
                n_lo = mid + 1'b1;
            end else begin
                n_hi = mid;
            end
        end

        if (ctrl.shift_rd) begin
            ram_raddr = j_m1[bis_pkg::AW-1:0];
        end

        if (ctrl.shift_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_j[bis_pkg::AW-1:0];
            ram_wdata = ram_rdata;
            n_j       = j_m1;
        end

        if (ctrl.insert) begin
            ram_we = 1'b1;
            n_fill = r_fill + 1'b1;
        end

        if (ctrl.emit) begin
            ram_raddr = r_idx;
            n_idx     = r_idx + 1'b1;
            n_ov_v    = 1'b1;
            n_ov_last = stat.emit_end;
            n_ov_ovf  = r_ovf;
            if (stat.emit_end) begin
                n_fill = '0;
                n_ovf  = 1'b0;
                n_idx  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
            r_ov_v <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_fill <= n_fill;
            r_ovf  <= n_ovf;
            r_ov_v <= n_ov_v;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val     <= n_val;
        r_last    <= n_last;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_j       <= n_j;
        r_ov_last <= n_ov_last;
        r_ov_ovf  <= n_ov_ovf;
    end

    assign busy                  = ctrl.busy;
    assign strobe                = r_ov_v;
    assign o_result.sorted_value = $signed(ram_rdata);
    assign o_result.last_out     = r_ov_last;
    assign o_result.overflow     = r_ov_ovf;

    `BIS_ASSERT_ALWAYS(a_fill_bound, r_fill <= bis_pkg::CW'(bis_pkg::DEPTH), "fill count above depth")
    `BIS_ASSERT_IMPL(a_search_order, ctrl.srch || ctrl.cmp, r_lo <= r_hi, "search bounds crossed")
    `BIS_ASSERT_IMPL(a_last_clears, strobe && o_result.last_out, r_fill == '0, "set not cleared after last")
    `BIS_ASSERT_IMPL(a_write_busy, ram_we, ctrl.busy && !strobe, "store written outside insert phase")

endmodule

// ===== src/bis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bis_seq.sv =====
// Sequencer of the sorter: search, shift, insert and emit phases.
module bis_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bis_pkg::t_stat i_stat,
    output bis_pkg::t_ctrl o_ctrl
);

    bis_pkg::t_state r_state;
    bis_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bis_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bis_pkg::S_IDLE: begin
                if (i_stat.start) begin
                    if (!i_stat.full) begin
                        n_state = bis_pkg::S_SRCH;
                    end else if (i_stat.in_last) begin
                        n_state = bis_pkg::S_EMIT;
                    end
                end
            end
            bis_pkg::S_SRCH: begin
                n_state = i_stat.lo_lt_hi ? bis_pkg::S_CMP : bis_pkg::S_SHIFT;
            end
            bis_pkg::S_CMP: begin
                n_state = bis_pkg::S_SRCH;
            end
            bis_pkg::S_SHIFT: begin
                if (i_stat.j_gt_pos) begin
                    n_state = bis_pkg::S_SHWR;
                end else begin
                    n_state = i_stat.last ? bis_pkg::S_EMIT : bis_pkg::S_IDLE;
                end
            end
            bis_pkg::S_SHWR: begin
                n_state = bis_pkg::S_SHIFT;
            end
            bis_pkg::S_EMIT: begin
                if (i_stat.emit_end) begin
                    n_state = bis_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bis_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            bis_pkg::S_IDLE: begin
                o_ctrl.load = i_stat.start;
            end
            bis_pkg::S_SRCH: begin
                o_ctrl.busy = 1'b1;
                o_ctrl.srch = 1'b1;
            end
            bis_pkg::S_CMP: begin
                o_ctrl.busy = 1'b1;
                o_ctrl.cmp  = 1'b1;
            end
            bis_pkg::S_SHIFT: begin
                o_ctrl.busy     = 1'b1;
                o_ctrl.shift_rd = i_stat.j_gt_pos;
                o_ctrl.insert   = !i_stat.j_gt_pos;
            end
            bis_pkg::S_SHWR: begin
                o_ctrl.busy     = 1'b1;
                o_ctrl.shift_wr = 1'b1;
            end
            bis_pkg::S_EMIT: begin
                o_ctrl.busy = 1'b1;
                o_ctrl.emit = 1'b1;
            end
            default: begin
                o_ctrl.busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== tb/tb_binary_insertion_sorter.sv =====
// Testbench for binary_insertion_sorter: directed and random set stimulus and a scoreboard predictor.
`timescale 1ns / 100ps

module tb_binary_insertion_sorter;
    import bis_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 136;
    localparam int REPORT_LIMIT  = 10;

    localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

    typedef enum int {
        FILL_RANDOM,
        FILL_RISING,
        FILL_FALLING,
        FILL_CLUSTER
    } t_fill_mode;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  in_item;
    logic      busy;
    logic      strobe;
    t_out_item out_item;

    // shadow copy of the sorter state
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_count;
    bit                       shadow_dropped;

    t_out_item sorted_due [$];
    int        mismatches;
    int        burst_left;
    int        cycles;

    binary_insertion_sorter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (in_item),
        .busy     (busy),
        .strobe   (strobe),
        .o_result (out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("binary_insertion_sorter verification failed");
            $finish;
        end
    end

    function automatic bit count_mismatch();
        mismatches++;
        return mismatches <= REPORT_LIMIT;
    endfunction

    // Insert one accepted element; on the set's last element release the sorted set.
    task automatic predict_element(input logic signed [DATA_W-1:0] value, input logic last);
        int slot;
        int j;
        if (shadow_count >= DEPTH) begin
            shadow_dropped = 1'b1;
        end else begin
            // upper bound: equal values land after the ones already stored
            slot = 0;
            while (slot < shadow_count && shadow_store[slot] <= value) slot++;
            for (j = shadow_count; j > slot; j--) shadow_store[j] = shadow_store[j-1];
            shadow_store[slot] = value;
            shadow_count++;
        end
        if (last) begin
            for (j = 0; j < shadow_count; j++) begin
                sorted_due.push_back('{sorted_value: shadow_store[j],
                                       last_out:     (j == shadow_count - 1),
                                       overflow:     shadow_dropped});
            end
            shadow_count   = 0;
            shadow_dropped = 1'b0;
        end
    endtask

    task automatic push_element(input logic signed [DATA_W-1:0] value, input logic last);
        start   <= 1'b1;
        in_item <= '{value: value, last_in: last};
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_element(value, last);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && strobe === 1'b1) begin
            if (sorted_due.size() == 0) begin
                if (count_mismatch())
                    $display("%0t: unexpected result value=%0d last=%b ovf=%b", $realtime,
                             out_item.sorted_value, out_item.last_out, out_item.overflow);
            end else begin
                want = sorted_due.pop_front();
                if (out_item.sorted_value !== want.sorted_value ||
                    out_item.last_out !== want.last_out ||
                    out_item.overflow !== want.overflow) begin
                    if (count_mismatch())
                        $display("%0t: mismatch exp value=%0d last=%b ovf=%b, got value=%0d last=%b ovf=%b",
                                 $realtime, want.sorted_value, want.last_out, want.overflow,
                                 out_item.sorted_value, out_item.last_out, out_item.overflow);
                end
            end
        end
    end

    task automatic test_extreme_values();
        push_element(MAX_VAL, 1'b0);
        push_element(MIN_VAL, 1'b0);
        push_element(32'sd0, 1'b0);
        push_element(-32'sd1, 1'b0);
        push_element(32'sd1, 1'b0);
        push_element(MAX_VAL, 1'b1);
    endtask

    task automatic test_single_element();
        push_element(MIN_VAL, 1'b1);
    endtask

    // 16 elements fill the store, the closing element is dropped
    task automatic test_store_overflow();
        int k;
        for (k = 0; k < DEPTH; k++) push_element(32'sd1000 - k * 7, 1'b0);
        push_element(-32'sd5, 1'b1);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input t_fill_mode mode,
                                                            input logic signed [DATA_W-1:0] base,
                                                            input int step, input int k);
        case (mode)
            FILL_RISING:  return base + k * step;
            FILL_FALLING: return base - k * step;
            FILL_CLUSTER: return signed'($urandom_range(0, 6)) - 3;
            default: begin
                case ($urandom_range(0, 7))
                    0:       return MIN_VAL;
                    1:       return MAX_VAL;
                    2:       return 32'sd0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task automatic test_random_sets();
        int         sent;
        int         len;
        int         k;
        int         step;
        t_fill_mode mode;
        logic signed [DATA_W-1:0] base;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(DEPTH + 1, DEPTH + 6);
                1:       len = DEPTH;
                default: len = $urandom_range(1, DEPTH - 1);
            endcase
            mode = t_fill_mode'($urandom_range(0, 3));
            base = $urandom;
            step = $urandom_range(1, 1000);
            for (k = 0; k < len; k++) push_element(pick_value(mode, base, step, k), k == len - 1);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        in_item        <= '0;
        shadow_count   = 0;
        shadow_dropped = 1'b0;
        mismatches     = 0;
        cycles         = 0;
        burst_left     = $urandom_range(0, 15);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_values();
        test_single_element();
        test_store_overflow();
        test_random_sets();

        if (start) start <= 1'b0;
        while (sorted_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("binary_insertion_sorter verification clean");
        end else begin
            $display("binary_insertion_sorter verification failed");
        end
        $finish;
    end

endmodule
